### hdl/vau_pkg.sv
// ----------------------------------------------------------------------------
// Vector unit package
// Shared constants, operation codes, stage payload types and the Q-format
// saturation helper for the three-component vector arithmetic pipeline.
// ----------------------------------------------------------------------------
package vau_pkg;

    // Number format and derived widths
    localparam int FRAC_BITS  = 16;
    localparam int DATA_W     = 32;
    localparam int PROD_W     = 2 * DATA_W;
    localparam int SUM_W      = PROD_W + 2;
    localparam int REM_W      = DATA_W + 1;
    localparam int LANES      = 3;
    localparam int NUM_PROD   = 2 * LANES;
    localparam int SQRT_STEPS = DATA_W;
    localparam int DIV_STEPS  = DATA_W;

    localparam logic [DATA_W-1:0] POS_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic [DATA_W-1:0] NEG_MIN = {1'b1, {(DATA_W-1){1'b0}}};
    localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'($signed(POS_MAX));
    localparam logic signed [SUM_W-1:0] SAT_LO = SUM_W'($signed(NEG_MIN));

    // Operation codes
    typedef enum logic [3:0] {
        OP_ADD   = 4'd0,
        OP_SUB   = 4'd1,
        OP_SCALE = 4'd2,
        OP_DIV   = 4'd3,
        OP_DOT   = 4'd4,
        OP_CROSS = 4'd5,
        OP_SQMAG = 4'd6,
        OP_MAG   = 4'd7,
        OP_NORM  = 4'd8
    } op_t;

    typedef logic [LANES-1:0][DATA_W-1:0] vec_t;

    typedef struct packed {
        logic [DATA_W-1:0] value;
        logic              ovf;
    } sat_t;

    // Square root section payload
    typedef struct packed {
        op_t               op;
        vec_t              a;
        logic [DATA_W-1:0] s;
        vec_t              r;
        logic [DATA_W-1:0] sc;
        logic              ovf;
        logic [PROD_W-1:0] rad;
        logic [REM_W-1:0]  rem;
        logic [DATA_W-1:0] root;
    } sq_t;

    // Divider section payload
    typedef struct packed {
        op_t               op;
        vec_t              r;
        logic [DATA_W-1:0] sc;
        logic              ovf;
        logic [DATA_W-1:0] d;
        logic              fault;
        vec_t              nlo;
        vec_t              rem;
        vec_t              quo;
        logic [LANES-1:0]  big;
        logic [LANES-1:0]  neg;
    } dv_t;

    // Finished result
    typedef struct packed {
        vec_t              r;
        logic [DATA_W-1:0] sc;
        logic              ovf;
        logic              fault;
    } res_t;

    // Clamp a wide signed value to the data range and flag the clamp
    function automatic sat_t sat32(input logic signed [SUM_W-1:0] v);
        sat_t res;
        if (v > SAT_HI) begin
            res.value = POS_MAX;
            res.ovf   = 1'b1;
        end else if (v < SAT_LO) begin
            res.value = NEG_MIN;
            res.ovf   = 1'b1;
        end else begin
            res.value = v[DATA_W-1:0];
            res.ovf   = 1'b0;
        end
        return res;
    endfunction

endpackage

### hdl/vector3_arithmetic_unit.sv
// ----------------------------------------------------------------------------
// Vector3 arithmetic unit
// Fixed-point add, subtract, scale, divide, dot, cross, squared magnitude,
// magnitude and normalize on signed three-component vectors.
// ----------------------------------------------------------------------------
// One item enters per clock while s_ready is high, that is while the skid
// register holds no result. Every operation runs
// through the same stages so results leave in order: input register, six
// 32x32 multipliers, a product adder, saturation, a 32-stage square root (one
// result bit per stage), a divisor setup stage, a 32-stage divider with three
// lanes (one quotient bit per stage), a finishing stage and the output
// register. The square root and divider depths set the latency. A skid
// register behind the pipeline lets s_ready come from a flop, so the pipeline
// holds only once both the output and skid registers are occupied. Results
// clamp to the signed 32-bit range with m_overflow set; a zero divisor or a
// zero vector under normalize returns zeros with m_divide_fault set.
module vector3_arithmetic_unit (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [3:0]          s_operation,
    input  logic signed [31:0]  s_ax,
    input  logic signed [31:0]  s_ay,
    input  logic signed [31:0]  s_az,
    input  logic signed [31:0]  s_bx,
    input  logic signed [31:0]  s_by,
    input  logic signed [31:0]  s_bz,
    input  logic signed [31:0]  s_scalar_in,
    output logic                m_valid,
    input  logic                m_ready,
    output logic signed [31:0]  m_rx,
    output logic signed [31:0]  m_ry,
    output logic signed [31:0]  m_rz,
    output logic signed [31:0]  m_scalar_out,
    output logic                m_overflow,
    output logic                m_divide_fault
);

    localparam int DW = vau_pkg::DATA_W;
    localparam int PW = vau_pkg::PROD_W;
    localparam int SW = vau_pkg::SUM_W;
    localparam int RW = vau_pkg::REM_W;
    localparam int NL = vau_pkg::LANES;
    localparam int NP = vau_pkg::NUM_PROD;
    localparam int NQ = vau_pkg::SQRT_STEPS;
    localparam int ND = vau_pkg::DIV_STEPS;
    localparam int FB = vau_pkg::FRAC_BITS;

    logic en;

    // Input stage
    logic               in_vld_reg;
    vau_pkg::op_t       in_op_reg;
    vau_pkg::vec_t      in_a_reg;
    vau_pkg::vec_t      in_b_reg;
    logic [DW-1:0]      in_s_reg;

    // Multiplier stage
    logic               mul_vld_reg;
    vau_pkg::op_t       mul_op_reg;
    vau_pkg::vec_t      mul_a_reg;
    logic [DW-1:0]      mul_s_reg;
    logic signed [DW-1:0] mx [NP];
    logic signed [DW-1:0] my [NP];
    logic signed [PW-1:0] prod_reg [NP];
    logic signed [PW-1:0] prod_next [NP];
    logic signed [DW:0]   addsub_reg [NL];
    logic signed [DW:0]   addsub_next [NL];

    // Sum stage
    logic               sum_vld_reg;
    vau_pkg::op_t       sum_op_reg;
    vau_pkg::vec_t      sum_a_reg;
    logic [DW-1:0]      sum_s_reg;
    logic signed [SW-1:0] sum3;
    logic signed [SW-1:0] pre_reg [NL];
    logic signed [SW-1:0] pre_next [NL];
    logic signed [SW-1:0] pre_sc_reg;
    logic signed [SW-1:0] pre_sc_next;
    logic [PW-1:0]      rad_reg;
    logic [PW-1:0]      rad_next;

    // Square root section
    vau_pkg::sat_t      pre_sat [NL];
    vau_pkg::sat_t      sc_sat;
    logic               sq_vld_reg [NQ+1];
    vau_pkg::sq_t       sq_reg [NQ+1];
    vau_pkg::sq_t       sq_next [NQ+1];
    logic [RW+1:0]      sq_try [NQ];
    logic [RW+1:0]      sq_trial [NQ];

    // Divider section
    logic               dv_vld_reg [ND+1];
    vau_pkg::dv_t       dv_reg [ND+1];
    vau_pkg::dv_t       dv_next [ND+1];
    logic [DW-1:0]      dv_mag [NL];
    logic [DW-1:0]      dv_head [NL];
    logic               dv_sneg;
    logic [DW:0]        dv_try [ND][NL];

    // Finish, output and skid
    logic               fin_vld_reg;
    vau_pkg::res_t      fin_reg;
    vau_pkg::res_t      fin_next;
    logic signed [SW-1:0] fin_q [NL];
    logic signed [SW-1:0] fin_v [NL];
    vau_pkg::sat_t      fin_sat [NL];
    logic               out_vld_reg;
    vau_pkg::res_t      out_reg;
    logic               skid_vld_reg;
    vau_pkg::res_t      skid_reg;

    // Whole pipeline advances unless the skid register is holding a result
    assign en      = !skid_vld_reg;
    assign s_ready = en;

    // Select multiplier operands and form add/subtract results
    always_comb begin
        for (int k = 0; k < NP; k++) begin
            mx[k] = '0;
            my[k] = '0;
        end
        unique case (in_op_reg) inside
            vau_pkg::OP_SCALE: begin
                for (int i = 0; i < NL; i++) begin
                    mx[i] = in_a_reg[i];
                    my[i] = in_s_reg;
                end
            end
            vau_pkg::OP_DOT: begin
                for (int i = 0; i < NL; i++) begin
                    mx[i] = in_a_reg[i];
                    my[i] = in_b_reg[i];
                end
            end
            vau_pkg::OP_CROSS: begin
                mx[0] = in_a_reg[1]; my[0] = in_b_reg[2];
                mx[1] = in_a_reg[2]; my[1] = in_b_reg[1];
                mx[2] = in_a_reg[2]; my[2] = in_b_reg[0];
                mx[3] = in_a_reg[0]; my[3] = in_b_reg[2];
                mx[4] = in_a_reg[0]; my[4] = in_b_reg[1];
                mx[5] = in_a_reg[1]; my[5] = in_b_reg[0];
            end
            vau_pkg::OP_SQMAG, vau_pkg::OP_MAG, vau_pkg::OP_NORM: begin
                for (int i = 0; i < NL; i++) begin
                    mx[i] = in_a_reg[i];
                    my[i] = in_a_reg[i];
                end
            end
            default: begin
            end
        endcase
        for (int k = 0; k < NP; k++) begin
            prod_next[k] = PW'(mx[k]) * PW'(my[k]);
        end
        for (int i = 0; i < NL; i++) begin
            if (in_op_reg == vau_pkg::OP_SUB) begin
                addsub_next[i] = (DW+1)'($signed(in_a_reg[i])) - (DW+1)'($signed(in_b_reg[i]));
            end else begin
                addsub_next[i] = (DW+1)'($signed(in_a_reg[i])) + (DW+1)'($signed(in_b_reg[i]));
            end
        end
    end

    // Combine products, dropping the fraction bits except in the square root radicand
    always_comb begin
        sum3 = SW'(prod_reg[0]) + SW'(prod_reg[1]) + SW'(prod_reg[2]);
        for (int i = 0; i < NL; i++) begin
            pre_next[i] = '0;
        end
        pre_sc_next = '0;
        rad_next    = sum3[PW-1:0];
        unique case (mul_op_reg) inside
            vau_pkg::OP_ADD, vau_pkg::OP_SUB: begin
                for (int i = 0; i < NL; i++) begin
                    pre_next[i] = SW'(addsub_reg[i]);
                end
            end
            vau_pkg::OP_SCALE: begin
                for (int i = 0; i < NL; i++) begin
                    pre_next[i] = SW'(prod_reg[i]) >>> FB;
                end
            end
            vau_pkg::OP_CROSS: begin
                for (int i = 0; i < NL; i++) begin
                    pre_next[i] = (SW'(prod_reg[2*i]) - SW'(prod_reg[2*i+1])) >>> FB;
                end
            end
            vau_pkg::OP_DOT, vau_pkg::OP_SQMAG: begin
                pre_sc_next = sum3 >>> FB;
            end
            default: begin
            end
        endcase
    end

    // Saturate, then take square root one result bit per stage
    always_comb begin
        sq_next[0].op   = sum_op_reg;
        sq_next[0].a    = sum_a_reg;
        sq_next[0].s    = sum_s_reg;
        sq_next[0].ovf  = 1'b0;
        for (int i = 0; i < NL; i++) begin
            pre_sat[i]        = vau_pkg::sat32(pre_reg[i]);
            sq_next[0].r[i]   = pre_sat[i].value;
            sq_next[0].ovf    = sq_next[0].ovf | pre_sat[i].ovf;
        end
        sc_sat          = vau_pkg::sat32(pre_sc_reg);
        sq_next[0].sc   = sc_sat.value;
        sq_next[0].ovf  = sq_next[0].ovf | sc_sat.ovf;
        sq_next[0].rad  = rad_reg;
        sq_next[0].rem  = '0;
        sq_next[0].root = '0;
        for (int k = 0; k < NQ; k++) begin
            sq_try[k]       = {sq_reg[k].rem, sq_reg[k].rad[PW-1 -: 2]};
            sq_trial[k]     = {1'b0, sq_reg[k].root, 2'b01};
            sq_next[k+1]     = sq_reg[k];
            sq_next[k+1].rad = sq_reg[k].rad << 2;
            if (sq_try[k] >= sq_trial[k]) begin
                sq_next[k+1].rem  = RW'(sq_try[k] - sq_trial[k]);
                sq_next[k+1].root = {sq_reg[k].root[DW-2:0], 1'b1};
            end else begin
                sq_next[k+1].rem  = sq_try[k][RW-1:0];
                sq_next[k+1].root = {sq_reg[k].root[DW-2:0], 1'b0};
            end
        end
    end

    // Set up divisor and lanes, then divide one quotient bit per stage
    always_comb begin
        dv_next[0].op    = sq_reg[NQ].op;
        dv_next[0].r     = sq_reg[NQ].r;
        dv_next[0].sc    = sq_reg[NQ].sc;
        dv_next[0].ovf   = sq_reg[NQ].ovf;
        if (sq_reg[NQ].op == vau_pkg::OP_MAG) begin
            dv_next[0].sc  = sq_reg[NQ].root[DW-1] ? vau_pkg::POS_MAX : sq_reg[NQ].root;
            dv_next[0].ovf = sq_reg[NQ].root[DW-1];
        end
        if (sq_reg[NQ].op == vau_pkg::OP_DIV) begin
            dv_next[0].d = sq_reg[NQ].s[DW-1] ? (~sq_reg[NQ].s + 1'b1) : sq_reg[NQ].s;
            dv_sneg      = sq_reg[NQ].s[DW-1];
        end else begin
            dv_next[0].d = sq_reg[NQ].root;
            dv_sneg      = 1'b0;
        end
        dv_next[0].fault = (dv_next[0].d == '0);
        for (int i = 0; i < NL; i++) begin
            dv_mag[i]  = sq_reg[NQ].a[i][DW-1] ? (~sq_reg[NQ].a[i] + 1'b1) : sq_reg[NQ].a[i];
            dv_head[i] = dv_mag[i] >> (DW - FB);
            dv_next[0].big[i] = (dv_head[i] >= dv_next[0].d);
            dv_next[0].rem[i] = dv_head[i];
            dv_next[0].nlo[i] = dv_mag[i] << FB;
            dv_next[0].quo[i] = '0;
            dv_next[0].neg[i] = sq_reg[NQ].a[i][DW-1] ^ dv_sneg;
        end
        for (int j = 0; j < ND; j++) begin
            dv_next[j+1] = dv_reg[j];
            for (int i = 0; i < NL; i++) begin
                dv_try[j][i]          = {dv_reg[j].rem[i], dv_reg[j].nlo[i][DW-1]};
                dv_next[j+1].nlo[i]   = dv_reg[j].nlo[i] << 1;
                if (dv_try[j][i] >= {1'b0, dv_reg[j].d}) begin
                    dv_next[j+1].rem[i] = DW'(dv_try[j][i] - {1'b0, dv_reg[j].d});
                    dv_next[j+1].quo[i] = {dv_reg[j].quo[i][DW-2:0], 1'b1};
                end else begin
                    dv_next[j+1].rem[i] = dv_try[j][i][DW-1:0];
                    dv_next[j+1].quo[i] = {dv_reg[j].quo[i][DW-2:0], 1'b0};
                end
            end
        end
    end

    // Apply quotient signs, saturate and resolve faults
    always_comb begin
        fin_next.r     = dv_reg[ND].r;
        fin_next.sc    = dv_reg[ND].sc;
        fin_next.ovf   = dv_reg[ND].ovf;
        fin_next.fault = 1'b0;
        for (int i = 0; i < NL; i++) begin
            fin_q[i]   = SW'($signed({1'b0, dv_reg[ND].quo[i]}));
            fin_v[i]   = dv_reg[ND].neg[i] ? -fin_q[i] : fin_q[i];
            fin_sat[i] = vau_pkg::sat32(fin_v[i]);
            if (dv_reg[ND].big[i]) begin
                fin_sat[i].value = dv_reg[ND].neg[i] ? vau_pkg::NEG_MIN : vau_pkg::POS_MAX;
                fin_sat[i].ovf   = 1'b1;
            end
        end
        if (dv_reg[ND].op == vau_pkg::OP_DIV || dv_reg[ND].op == vau_pkg::OP_NORM) begin
            if (dv_reg[ND].fault) begin
                fin_next.r     = '0;
                fin_next.ovf   = 1'b0;
                fin_next.fault = 1'b1;
            end else begin
                fin_next.ovf = 1'b0;
                for (int i = 0; i < NL; i++) begin
                    fin_next.r[i] = fin_sat[i].value;
                    fin_next.ovf  = fin_next.ovf | fin_sat[i].ovf;
                end
            end
        end
    end

    // Advance valid bits and manage output and skid occupancy
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg   <= 1'b0;
            mul_vld_reg  <= 1'b0;
            sum_vld_reg  <= 1'b0;
            for (int k = 0; k <= NQ; k++) begin
                sq_vld_reg[k] <= 1'b0;
            end
            for (int j = 0; j <= ND; j++) begin
                dv_vld_reg[j] <= 1'b0;
            end
            fin_vld_reg  <= 1'b0;
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end else begin
            if (en) begin
                in_vld_reg    <= s_valid;
                mul_vld_reg   <= in_vld_reg;
                sum_vld_reg   <= mul_vld_reg;
                sq_vld_reg[0] <= sum_vld_reg;
                for (int k = 0; k < NQ; k++) begin
                    sq_vld_reg[k+1] <= sq_vld_reg[k];
                end
                dv_vld_reg[0] <= sq_vld_reg[NQ];
                for (int j = 0; j < ND; j++) begin
                    dv_vld_reg[j+1] <= dv_vld_reg[j];
                end
                fin_vld_reg   <= dv_vld_reg[ND];
            end
            if (!out_vld_reg || m_ready) begin
                if (skid_vld_reg) begin
                    out_vld_reg  <= 1'b1;
                    skid_vld_reg <= 1'b0;
                end else begin
                    out_vld_reg  <= en && fin_vld_reg;
                end
            end else if (en && fin_vld_reg) begin
                skid_vld_reg <= 1'b1;
            end
        end
    end

    // Hold or advance stage payloads
    always_ff @(posedge aclk) begin
        if (en) begin
            in_op_reg  <= vau_pkg::op_t'(s_operation);
            in_a_reg   <= {s_az, s_ay, s_ax};
            in_b_reg   <= {s_bz, s_by, s_bx};
            in_s_reg   <= s_scalar_in;
            mul_op_reg <= in_op_reg;
            mul_a_reg  <= in_a_reg;
            mul_s_reg  <= in_s_reg;
            for (int k = 0; k < NP; k++) begin
                prod_reg[k] <= prod_next[k];
            end
            for (int i = 0; i < NL; i++) begin
                addsub_reg[i] <= addsub_next[i];
                pre_reg[i]    <= pre_next[i];
            end
            sum_op_reg <= mul_op_reg;
            sum_a_reg  <= mul_a_reg;
            sum_s_reg  <= mul_s_reg;
            pre_sc_reg <= pre_sc_next;
            rad_reg    <= rad_next;
            for (int k = 0; k <= NQ; k++) begin
                sq_reg[k] <= sq_next[k];
            end
            for (int j = 0; j <= ND; j++) begin
                dv_reg[j] <= dv_next[j];
            end
            fin_reg <= fin_next;
        end
        if (!out_vld_reg || m_ready) begin
            out_reg <= skid_vld_reg ? skid_reg : fin_reg;
        end
        if (en && fin_vld_reg && out_vld_reg && !m_ready) begin
            skid_reg <= fin_reg;
        end
    end

    assign m_valid        = out_vld_reg;
    assign m_rx           = out_reg.r[0];
    assign m_ry           = out_reg.r[1];
    assign m_rz           = out_reg.r[2];
    assign m_scalar_out   = out_reg.sc;
    assign m_overflow     = out_reg.ovf;
    assign m_divide_fault = out_reg.fault;

    // A fault result is all zeros and never also saturated
    a_fault_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_divide_fault |-> !m_overflow && m_rx == '0 && m_ry == '0 &&
        m_rz == '0 && m_scalar_out == '0)
        else $error("divide fault with nonzero result or overflow");

    // A scalar result leaves the vector fields at zero
    a_scalar_only: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_scalar_out != '0 |-> m_rx == '0 && m_ry == '0 && m_rz == '0)
        else $error("scalar and vector results both nonzero");

    // Skid register fills only behind an occupied output register
    a_skid_order: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_vld_reg |-> out_vld_reg)
        else $error("skid holds a result while output is empty");

endmodule

### verif/vector3_arithmetic_unit_checker.sv
// ----------------------------------------------------------------------------
// Vector3 arithmetic unit checker
// Watches the input and result channels. For every input transfer it predicts
// the result with its own fixed-point model. It then compares each result
// transfer, field by field, with the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module vector3_arithmetic_unit_checker (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    input  logic               s_ready,
    input  logic [3:0]         s_operation,
    input  logic signed [31:0] s_ax,
    input  logic signed [31:0] s_ay,
    input  logic signed [31:0] s_az,
    input  logic signed [31:0] s_bx,
    input  logic signed [31:0] s_by,
    input  logic signed [31:0] s_bz,
    input  logic signed [31:0] s_scalar_in,
    input  logic               m_valid,
    input  logic               m_ready,
    input  logic signed [31:0] m_rx,
    input  logic signed [31:0] m_ry,
    input  logic signed [31:0] m_rz,
    input  logic signed [31:0] m_scalar_out,
    input  logic               m_overflow,
    input  logic               m_divide_fault,
    output int                 mismatches,
    output int                 pending,
    output int                 results_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef logic signed [95:0] wide_t;

    typedef struct {
        logic [31:0] rx, ry, rz, sc;
        logic        ovf, fault;
    } vec_result_t;

    vec_result_t expected_results[$];

    // Clamp to 32 bits and note any clamp
    function automatic logic [31:0] clamp_q(input wide_t v, inout logic hit);
        if (v > wide_t'(32'sh7fffffff)) begin
            hit = 1'b1;
            return 32'h7fffffff;
        end else if (v < -wide_t'(64'sh80000000)) begin
            hit = 1'b1;
            return 32'h80000000;
        end
        return v[31:0];
    endfunction

    // Floored square root of a sum of squares
    function automatic wide_t floor_root(input wide_t v);
        wide_t r;
        wide_t t;
        r = 0;
        for (int i = 33; i >= 0; i--) begin
            t = r | (wide_t'(1) << i);
            if (t * t <= v) begin
                r = t;
            end
        end
        return r;
    endfunction

    function automatic vec_result_t predict_vector_op(
        input logic [3:0] op,
        input wide_t ax, ay, az, bx, by, bz, s
    );
        vec_result_t res;
        wide_t a[3];
        wide_t b[3];
        wide_t one;
        wide_t m;
        logic  hit;
        logic [31:0] r[3];
        one = wide_t'(1) << vau_pkg::FRAC_BITS;
        a[0] = ax; a[1] = ay; a[2] = az;
        b[0] = bx; b[1] = by; b[2] = bz;
        hit = 1'b0;
        r[0] = '0; r[1] = '0; r[2] = '0;
        res.sc = '0;
        res.fault = 1'b0;
        case (op)
            vau_pkg::OP_ADD: for (int i = 0; i < 3; i++) r[i] = clamp_q(a[i] + b[i], hit);
            vau_pkg::OP_SUB: for (int i = 0; i < 3; i++) r[i] = clamp_q(a[i] - b[i], hit);
            vau_pkg::OP_SCALE: begin
                for (int i = 0; i < 3; i++)
                    r[i] = clamp_q((a[i] * s) >>> vau_pkg::FRAC_BITS, hit);
            end
            vau_pkg::OP_DIV: begin
                if (s == 0) res.fault = 1'b1;
                else for (int i = 0; i < 3; i++) r[i] = clamp_q((a[i] * one) / s, hit);
            end
            vau_pkg::OP_DOT: begin
                res.sc = clamp_q((a[0]*b[0] + a[1]*b[1] + a[2]*b[2]) >>> vau_pkg::FRAC_BITS,
                                 hit);
            end
            vau_pkg::OP_CROSS: begin
                r[0] = clamp_q((a[1]*b[2] - a[2]*b[1]) >>> vau_pkg::FRAC_BITS, hit);
                r[1] = clamp_q((a[2]*b[0] - a[0]*b[2]) >>> vau_pkg::FRAC_BITS, hit);
                r[2] = clamp_q((a[0]*b[1] - a[1]*b[0]) >>> vau_pkg::FRAC_BITS, hit);
            end
            vau_pkg::OP_SQMAG: begin
                res.sc = clamp_q((a[0]*a[0] + a[1]*a[1] + a[2]*a[2]) >>> vau_pkg::FRAC_BITS,
                                 hit);
            end
            vau_pkg::OP_MAG: begin
                res.sc = clamp_q(floor_root(a[0]*a[0] + a[1]*a[1] + a[2]*a[2]), hit);
            end
            vau_pkg::OP_NORM: begin
                m = floor_root(a[0]*a[0] + a[1]*a[1] + a[2]*a[2]);
                if (m == 0) res.fault = 1'b1;
                else for (int i = 0; i < 3; i++) r[i] = clamp_q((a[i] * one) / m, hit);
            end
            default: ;
        endcase
        res.rx = r[0]; res.ry = r[1]; res.rz = r[2];
        res.ovf = hit;
        return res;
    endfunction

    assign pending = expected_results.size();

    // Predict on input transfers, compare on result transfers
    always @(posedge aclk) begin
        vec_result_t exp_r;
        if (!aresetn) begin
            expected_results.delete();
            mismatches <= 0;
            results_seen <= 0;
        end else begin
            if (s_valid && s_ready) begin
                expected_results.push_back(predict_vector_op(s_operation,
                    s_ax, s_ay, s_az, s_bx, s_by, s_bz, s_scalar_in));
            end
            if (m_valid && m_ready) begin
                results_seen <= results_seen + 1;
                if (expected_results.size() == 0) begin
                    if (mismatches < 10) $display("ERROR: result transfer with none expected");
                    mismatches <= mismatches + 1;
                end else begin
                    exp_r = expected_results.pop_front();
                    if (m_rx !== exp_r.rx || m_ry !== exp_r.ry || m_rz !== exp_r.rz ||
                        m_scalar_out !== exp_r.sc || m_overflow !== exp_r.ovf ||
                        m_divide_fault !== exp_r.fault) begin
                        if (mismatches < 10) begin
                            $display("ERROR: exp r=(%h %h %h) sc=%h ovf=%b df=%b",
                                exp_r.rx, exp_r.ry, exp_r.rz, exp_r.sc, exp_r.ovf, exp_r.fault);
                            $display("       got r=(%h %h %h) sc=%h ovf=%b df=%b",
                                m_rx, m_ry, m_rz, m_scalar_out, m_overflow, m_divide_fault);
                        end
                        mismatches <= mismatches + 1;
                    end
                end
            end
        end
    end

endmodule

### verif/vector3_arithmetic_unit_tb.sv
// ----------------------------------------------------------------------------
// Vector3 arithmetic unit testbench
// Drives directed corner items and then random items at random rates. It
// stalls the result side at random and once for a long stretch. The checker
// beside the block does the prediction and comparison.
// ----------------------------------------------------------------------------
module vector3_arithmetic_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT = 3000;
    localparam int RANDOM_ITEMS = 600;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic [3:0]         s_operation = '0;
    logic signed [31:0] s_ax = '0, s_ay = '0, s_az = '0;
    logic signed [31:0] s_bx = '0, s_by = '0, s_bz = '0;
    logic signed [31:0] s_scalar_in = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic signed [31:0] m_rx, m_ry, m_rz, m_scalar_out;
    logic               m_overflow, m_divide_fault;
    int                 mismatches, pending, results_seen;
    int                 idle_cycles = 0;
    int                 items_sent = 0;

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    vector3_arithmetic_unit u_top (.*);

    vector3_arithmetic_unit_checker u_checker (.*);

    // Stop the run if nothing moves for too long
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("Timeout after %0d idle cycles", idle_cycles);
            $display("** vector3_arithmetic_unit: FAILED **");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Receiver: random stalls plus one long hold-off mid-run
    initial begin
        int gap;
        int taken;
        taken = 0;
        @(posedge aclk iff aresetn);
        forever begin
            gap = (taken % 200 < 60) ? 0 : $urandom_range(0, 5);
            if (taken == 250) gap = 300;
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
            taken++;
        end
    end

    // Offer one item, hold it until the transfer
    task automatic send_vector_item(input logic [3:0] op,
            input logic [31:0] ax, ay, az, bx, by, bz, sc, input int gap);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_operation <= op;
        s_ax <= ax; s_ay <= ay; s_az <= az;
        s_bx <= bx; s_by <= by; s_bz <= bz;
        s_scalar_in <= sc;
        s_valid <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        items_sent++;
    endtask

    // Random operand: modest or full-range values, sometimes zero
    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 3))
            0: return $urandom();
            1: return 32'($signed($urandom_range(0, 32'h7ffff)) - 32'sh40000);
            2: return 32'($signed($urandom_range(0, 32'h7fffff)) - 32'sh400000);
            default: return $urandom_range(0, 3) == 0 ? 32'h0 : $urandom();
        endcase
    endfunction

    initial begin
        logic [3:0] op;
        logic [31:0] sc;
        int gap;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed corners: each operation, saturation, zero divisor, zero vector, unused codes
        send_vector_item(vau_pkg::OP_ADD, 32'h7fffffff, 32'h80000000, 32'h1,
                         32'h1, 32'h80000000, 32'h2, 0, 0);
        send_vector_item(vau_pkg::OP_SUB, 32'h80000000, 32'h7fffffff, 32'h0,
                         32'h1, 32'hffffffff, 32'h0, 0, 0);
        send_vector_item(vau_pkg::OP_SCALE, 32'h7fffffff, 32'h80000000, 32'hfffffffd,
                         0, 0, 0, 32'h80000000, 0);
        send_vector_item(vau_pkg::OP_SCALE, 32'h00018000, 32'hffff0000, 32'h1,
                         0, 0, 0, 32'h00008000, 1);
        send_vector_item(vau_pkg::OP_DIV, 32'h00030000, 32'hfffd0000, 32'h7fffffff,
                         0, 0, 0, 0, 0);
        send_vector_item(vau_pkg::OP_DIV, 32'h7fffffff, 32'h80000000, 32'h00050000,
                         0, 0, 0, 32'h1, 0);
        send_vector_item(vau_pkg::OP_DIV, 32'h80000000, 32'h1, 32'hffffffff,
                         0, 0, 0, 32'hffffffff, 2);
        send_vector_item(vau_pkg::OP_DOT, 32'h80000000, 32'h80000000, 32'h80000000,
                         32'h80000000, 32'h80000000, 32'h80000000, 0, 0);
        send_vector_item(vau_pkg::OP_DOT, 32'h80000000, 32'h7fffffff, 32'h3,
                         32'h7fffffff, 32'h7fffffff, 32'hfffffffb, 0, 0);
        send_vector_item(vau_pkg::OP_CROSS, 32'h80000000, 32'h7fffffff, 32'h80000000,
                         32'h7fffffff, 32'h80000000, 32'h7fffffff, 0, 0);
        send_vector_item(vau_pkg::OP_CROSS, 32'h00010000, 0, 0, 0, 32'h00010000, 0, 0, 3);
        send_vector_item(vau_pkg::OP_SQMAG, 32'h80000000, 32'h80000000, 32'h80000000,
                         0, 0, 0, 0, 0);
        send_vector_item(vau_pkg::OP_SQMAG, 32'h00000100, 32'hffffff00, 32'h1,
                         0, 0, 0, 0, 0);
        send_vector_item(vau_pkg::OP_MAG, 32'h80000000, 32'h80000000, 32'h80000000,
                         0, 0, 0, 0, 0);
        send_vector_item(vau_pkg::OP_MAG, 32'h00030000, 32'h00040000, 0, 0, 0, 0, 0, 0);
        send_vector_item(vau_pkg::OP_NORM, 0, 0, 0, 0, 0, 0, 0, 0);
        send_vector_item(vau_pkg::OP_NORM, 32'h00030000, 32'hfffc0000, 0, 0, 0, 0, 0, 1);
        send_vector_item(vau_pkg::OP_NORM, 32'h1, 0, 0, 0, 0, 0, 0, 0);
        send_vector_item(vau_pkg::OP_NORM, 32'h80000000, 32'h7fffffff, 32'h80000000,
                         0, 0, 0, 0, 0);
        for (int u = 9; u < 16; u++) begin
            send_vector_item(4'(u), $urandom(), $urandom(), $urandom(),
                             $urandom(), $urandom(), $urandom(), $urandom(), 0);
        end

        // Random items, some runs back to back; drain once partway through
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == 400) begin
                s_valid <= 1'b0;
                while (pending != 0) @(posedge aclk);
            end
            op = ($urandom_range(0, 15) == 0) ? 4'($urandom_range(9, 15))
                                              : 4'($urandom_range(0, 8));
            sc = ($urandom_range(0, 15) == 0) ? 32'h0 : pick_value();
            gap = (n % 150 < 40) ? 0 : $urandom_range(0, 5);
            send_vector_item(op, pick_value(), pick_value(), pick_value(),
                             pick_value(), pick_value(), pick_value(), sc, gap);
        end
        s_valid <= 1'b0;

        // Drain and settle
        while (pending != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);

        $display("Ran %0d items over all nine operations and unused codes,", items_sent);
        $display("%0d results checked with random and long output stalls", results_seen);
        if (mismatches == 0 && pending == 0) begin
            $display("** vector3_arithmetic_unit: PASSED **");
        end else begin
            $display("** vector3_arithmetic_unit: FAILED **");
        end
        $finish;
    end

endmodule
